// ----- rtl/core/sha512_pkg.sv -----
// Shared types, constants and round functions of the SHA-512 hash engine.
package sha512_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ROUNDS      = 80;

  localparam logic [63:0] PAD_WORD = 64'h8000_0000_0000_0000;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic [63:0] word;
    logic        last;
    logic        extra_pad;
    logic [63:0] length;
  } entry_t;

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

  function automatic logic [63:0] initial_hash(input logic [2:0] idx);
    logic [63:0] v;
    unique case (idx)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      3'd7: v = 64'h5be0cd19137e2179;
      default: v = '0;
    endcase
    initial_hash = v;
  endfunction

  function automatic logic [63:0] round_const(input logic [6:0] idx);
    logic [63:0] v;
    unique case (idx)
      7'd0:  v = 64'h428a2f98d728ae22; 7'd1:  v = 64'h7137449123ef65cd;
      7'd2:  v = 64'hb5c0fbcfec4d3b2f; 7'd3:  v = 64'he9b5dba58189dbbc;
      7'd4:  v = 64'h3956c25bf348b538; 7'd5:  v = 64'h59f111f1b605d019;
      7'd6:  v = 64'h923f82a4af194f9b; 7'd7:  v = 64'hab1c5ed5da6d8118;
      7'd8:  v = 64'hd807aa98a3030242; 7'd9:  v = 64'h12835b0145706fbe;
      7'd10: v = 64'h243185be4ee4b28c; 7'd11: v = 64'h550c7dc3d5ffb4e2;
      7'd12: v = 64'h72be5d74f27b896f; 7'd13: v = 64'h80deb1fe3b1696b1;
      7'd14: v = 64'h9bdc06a725c71235; 7'd15: v = 64'hc19bf174cf692694;
      7'd16: v = 64'he49b69c19ef14ad2; 7'd17: v = 64'hefbe4786384f25e3;
      7'd18: v = 64'h0fc19dc68b8cd5b5; 7'd19: v = 64'h240ca1cc77ac9c65;
      7'd20: v = 64'h2de92c6f592b0275; 7'd21: v = 64'h4a7484aa6ea6e483;
      7'd22: v = 64'h5cb0a9dcbd41fbd4; 7'd23: v = 64'h76f988da831153b5;
      7'd24: v = 64'h983e5152ee66dfab; 7'd25: v = 64'ha831c66d2db43210;
      7'd26: v = 64'hb00327c898fb213f; 7'd27: v = 64'hbf597fc7beef0ee4;
      7'd28: v = 64'hc6e00bf33da88fc2; 7'd29: v = 64'hd5a79147930aa725;
      7'd30: v = 64'h06ca6351e003826f; 7'd31: v = 64'h142929670a0e6e70;
      7'd32: v = 64'h27b70a8546d22ffc; 7'd33: v = 64'h2e1b21385c26c926;
      7'd34: v = 64'h4d2c6dfc5ac42aed; 7'd35: v = 64'h53380d139d95b3df;
      7'd36: v = 64'h650a73548baf63de; 7'd37: v = 64'h766a0abb3c77b2a8;
      7'd38: v = 64'h81c2c92e47edaee6; 7'd39: v = 64'h92722c851482353b;
      7'd40: v = 64'ha2bfe8a14cf10364; 7'd41: v = 64'ha81a664bbc423001;
      7'd42: v = 64'hc24b8b70d0f89791; 7'd43: v = 64'hc76c51a30654be30;
      7'd44: v = 64'hd192e819d6ef5218; 7'd45: v = 64'hd69906245565a910;
      7'd46: v = 64'hf40e35855771202a; 7'd47: v = 64'h106aa07032bbd1b8;
      7'd48: v = 64'h19a4c116b8d2d0c8; 7'd49: v = 64'h1e376c085141ab53;
      7'd50: v = 64'h2748774cdf8eeb99; 7'd51: v = 64'h34b0bcb5e19b48a8;
      7'd52: v = 64'h391c0cb3c5c95a63; 7'd53: v = 64'h4ed8aa4ae3418acb;
      7'd54: v = 64'h5b9cca4f7763e373; 7'd55: v = 64'h682e6ff3d6b2b8a3;
      7'd56: v = 64'h748f82ee5defb2fc; 7'd57: v = 64'h78a5636f43172f60;
      7'd58: v = 64'h84c87814a1f0ab72; 7'd59: v = 64'h8cc702081a6439ec;
      7'd60: v = 64'h90befffa23631e28; 7'd61: v = 64'ha4506cebde82bde9;
      7'd62: v = 64'hbef9a3f7b2c67915; 7'd63: v = 64'hc67178f2e372532b;
      7'd64: v = 64'hca273eceea26619c; 7'd65: v = 64'hd186b8c721c0c207;
      7'd66: v = 64'heada7dd6cde0eb1e; 7'd67: v = 64'hf57d4f7fee6ed178;
      7'd68: v = 64'h06f067aa72176fba; 7'd69: v = 64'h0a637dc5a2c898a6;
      7'd70: v = 64'h113f9804bef90dae; 7'd71: v = 64'h1b710b35131c471b;
      7'd72: v = 64'h28db77f523047d84; 7'd73: v = 64'h32caab7b40c72493;
      7'd74: v = 64'h3c9ebe0a15c9bebc; 7'd75: v = 64'h431d67c49c100d4c;
      7'd76: v = 64'h4cc5d4becb3e42b6; 7'd77: v = 64'h597f299cfc657e2a;
      7'd78: v = 64'h5fcb6fab3ad6faec; 7'd79: v = 64'h6c44198c4a475817;
      default: v = '0;
    endcase
    round_const = v;
  endfunction

endpackage

// ----- rtl/core/sha512_front.sv -----
// Input side: counts message bits, pads the final word and classifies each item.
module sha512_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [63:0]           in_data_word,
  input  logic [3:0]            in_byte_count,
  input  logic                  in_last_word,
  output logic                  push,
  output sha512_pkg::entry_t    push_entry,
  input  logic                  queue_full
);

  logic [63:0] bits_r, bits_nxt;
  logic [3:0]  count;
  logic [63:0] padded;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // Only the final word may be short; anything above eight counts as eight.
  always_comb begin
    if (!in_last_word || in_byte_count > 4'd8) begin
      count = 4'd8;
    end else begin
      count = in_byte_count;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < count) begin
        padded[63 - 8*i -: 8] = in_data_word[63 - 8*i -: 8];
      end else if (4'(i) == count) begin
        padded[63 - 8*i -: 8] = sha512_pkg::PAD_BYTE;
      end else begin
        padded[63 - 8*i -: 8] = 8'h00;
      end
    end
  end

  assign bits_nxt = bits_r + 64'({count, 3'b000});

  always_comb begin
    push_entry.word      = (count == 4'd8) ? in_data_word : padded;
    push_entry.last      = in_last_word;
    push_entry.extra_pad = in_last_word && (count == 4'd8);
    push_entry.length    = bits_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else if (push) begin
      bits_r <= in_last_word ? 64'd0 : bits_nxt;
    end
  end

endmodule

// ----- rtl/core/sha512_queue.sv -----
// Short queue of classified items between the front and the back.
module sha512_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  sha512_pkg::entry_t push_entry,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop,
  output sha512_pkg::entry_t pop_entry
);

  localparam int unsigned DEPTH = sha512_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sha512_pkg::entry_t slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_entry = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/sha512_back.sv -----
// Back end: block buffer, padding sequencer, one-round-per-cycle compression and digest output.
module sha512_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  sha512_pkg::entry_t q_entry,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_digest_word,
  output logic               out_digest_last
);

  typedef enum logic [5:0] {
    ST_TAKE   = 6'b000001,
    ST_PAD    = 6'b000010,
    ST_FILL   = 6'b000100,
    ST_ROUND  = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] buf_r   [16];
  logic [63:0] buf_nxt [16];
  logic [63:0] vars_r  [8];
  logic [63:0] vars_nxt[8];
  logic [63:0] chain_r [8];
  logic [63:0] chain_nxt[8];
  logic [3:0]  pos_r, pos_nxt;
  logic [6:0]  round_r, round_nxt;
  logic [2:0]  emit_idx_r, emit_idx_nxt;
  logic        tail_r, tail_nxt;
  logic        pad_pending_r, pad_pending_nxt;
  logic        fill_first_r, fill_first_nxt;
  logic        length_done_r, length_done_nxt;
  logic [63:0] length_r, length_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_word_r, out_word_nxt;
  logic        out_last_r, out_last_nxt;

  logic        put;
  logic [63:0] put_word;
  logic [63:0] t1, t2, w_new;
  logic        out_free;

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_digest_last = out_last_r;
  assign out_free        = !out_valid_r || out_ready;

  always_comb begin
    t1 = vars_r[7] + sha512_pkg::big_sigma1(vars_r[4])
       + ((vars_r[4] & vars_r[5]) ^ (~vars_r[4] & vars_r[6]))
       + sha512_pkg::round_const(round_r) + buf_r[0];
    t2 = sha512_pkg::big_sigma0(vars_r[0])
       + ((vars_r[0] & vars_r[1]) ^ (vars_r[0] & vars_r[2]) ^ (vars_r[1] & vars_r[2]));
    w_new = sha512_pkg::small_sigma1(buf_r[14]) + buf_r[9]
          + sha512_pkg::small_sigma0(buf_r[1]) + buf_r[0];
  end

  always_comb begin
    state_nxt       = state_r;
    buf_nxt         = buf_r;
    vars_nxt        = vars_r;
    chain_nxt       = chain_r;
    pos_nxt         = pos_r;
    round_nxt       = round_r;
    emit_idx_nxt    = emit_idx_r;
    tail_nxt        = tail_r;
    pad_pending_nxt = pad_pending_r;
    fill_first_nxt  = fill_first_r;
    length_done_nxt = length_done_r;
    length_nxt      = length_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_word_nxt    = out_word_r;
    out_last_nxt    = out_last_r;
    q_pop           = 1'b0;
    put             = 1'b0;
    put_word        = '0;

    unique case (state_r)
      ST_TAKE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          put      = 1'b1;
          put_word = q_entry.word;
          if (q_entry.last) begin
            tail_nxt        = 1'b1;
            pad_pending_nxt = q_entry.extra_pad;
            fill_first_nxt  = 1'b1;
            length_nxt      = q_entry.length;
          end
        end
      end
      ST_PAD: begin
        put             = 1'b1;
        put_word        = sha512_pkg::PAD_WORD;
        pad_pending_nxt = 1'b0;
      end
      ST_FILL: begin
        // The length goes in the last slot, unless the padding has just filled
        // the slot before it, in which case a whole block of zeros comes first.
        put            = 1'b1;
        fill_first_nxt = 1'b0;
        if (pos_r == 4'd15 && !fill_first_r) begin
          put_word        = length_r;
          length_done_nxt = 1'b1;
        end
      end
      ST_ROUND: begin
        vars_nxt[7] = vars_r[6];
        vars_nxt[6] = vars_r[5];
        vars_nxt[5] = vars_r[4];
        vars_nxt[4] = vars_r[3] + t1;
        vars_nxt[3] = vars_r[2];
        vars_nxt[2] = vars_r[1];
        vars_nxt[1] = vars_r[0];
        vars_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          buf_nxt[i] = buf_r[i + 1];
        end
        buf_nxt[15] = w_new;
        round_nxt   = round_r + 7'd1;
        if (round_r == 7'(sha512_pkg::ROUNDS - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
        priority if (length_done_r) begin
          state_nxt = ST_EMIT;
        end else if (pad_pending_r) begin
          state_nxt = ST_PAD;
        end else if (tail_r) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_TAKE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = chain_r[emit_idx_r];
          out_last_nxt  = (emit_idx_r == 3'd7);
          emit_idx_nxt  = emit_idx_r + 3'd1;
          if (emit_idx_r == 3'd7) begin
            for (int i = 0; i < 8; i++) begin
              chain_nxt[i] = sha512_pkg::initial_hash(3'(i));
            end
            pos_nxt         = '0;
            tail_nxt        = 1'b0;
            length_done_nxt = 1'b0;
            state_nxt       = ST_TAKE;
          end
        end
      end
      default: state_nxt = ST_TAKE;
    endcase

    if (put) begin
      buf_nxt[pos_r] = put_word;
      pos_nxt        = pos_r + 4'd1;
      priority if (pos_r == 4'd15) begin
        // A full block: load the working variables and start the rounds.
        vars_nxt  = chain_r;
        round_nxt = '0;
        state_nxt = ST_ROUND;
      end else if (pad_pending_nxt) begin
        state_nxt = ST_PAD;
      end else if (tail_nxt) begin
        state_nxt = ST_FILL;
      end else begin
        state_nxt = ST_TAKE;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r      <= buf_nxt;
    vars_r     <= vars_nxt;
    round_r    <= round_nxt;
    length_r   <= length_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_TAKE;
      pos_r         <= '0;
      emit_idx_r    <= '0;
      tail_r        <= 1'b0;
      pad_pending_r <= 1'b0;
      fill_first_r  <= 1'b0;
      length_done_r <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= sha512_pkg::initial_hash(3'(i));
      end
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      emit_idx_r    <= emit_idx_nxt;
      tail_r        <= tail_nxt;
      pad_pending_r <= pad_pending_nxt;
      fill_first_r  <= fill_first_nxt;
      length_done_r <= length_done_nxt;
      out_valid_r   <= out_valid_nxt;
      chain_r       <= chain_nxt;
    end
  end

endmodule

// ----- rtl/core/sha512_hash_engine.sv -----
// SHA-512 engine: takes big-endian 64-bit message words and returns the eight
// digest words after the final word. Each word is accepted into a two-item
// queue; the back end stores it in the block buffer, and every sixteenth word
// starts the compression, which runs one round per cycle over 80 rounds and
// then folds the result into the chaining value. The back end takes no words
// while it compresses. The final word adds padding and length words, one or
// two compressions and the eight digest words, one digest word per cycle while
// the receiver keeps ready high. The front keeps taking items while the back
// works, until the queue is full. After the eighth digest word the engine
// starts again from the initial hash value.
module sha512_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_digest_word,
  output logic        out_digest_last
);

  logic               push, queue_full, q_valid, q_pop;
  sha512_pkg::entry_t push_entry, q_entry;

  sha512_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .push          (push),
    .push_entry    (push_entry),
    .queue_full    (queue_full)
  );

  sha512_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  sha512_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_entry         (q_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_digest_last (out_digest_last)
  );

endmodule

// ----- rtl/core/sha512_checker.sv -----
// Port-level checks on the SHA-512 engine and the bind that attaches them.
module sha512_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_word,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_digest_word,
  input logic        out_digest_last
);

  logic [2:0] beat_r;
  logic [2:0] lasts_in_r, lasts_out_r;
  logic [2:0] pending;

  assign pending = lasts_in_r - lasts_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r      <= '0;
      lasts_in_r  <= '0;
      lasts_out_r <= '0;
    end else begin
      if (out_valid && out_ready) begin
        beat_r <= beat_r + 3'd1;
        if (out_digest_last) begin
          lasts_out_r <= lasts_out_r + 3'd1;
        end
      end
      if (in_valid && in_ready && in_last_word) begin
        lasts_in_r <= lasts_in_r + 3'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digest_word)
                                && $stable(out_digest_last))
    else $error("digest item changed while stalled");

  // Every eighth digest item, and only that one, closes a digest.
  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digest_last == (beat_r == 3'd7)))
    else $error("digest_last out of place");

  // A digest only appears for a message whose final word has gone in.
  a_no_orphan_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pending != 3'd0))
    else $error("digest item without a finished message");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind sha512_hash_engine sha512_checker u_sha512_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_last_word    (in_last_word),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_digest_last (out_digest_last)
);

// ----- sim/sha512_digest_monitor.sv -----
// Watches both channels of the SHA-512 engine, predicts each digest and checks every result item.
`timescale 1ns / 1ps

module sha512_digest_monitor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_digest_word,
  input  logic        out_digest_last,
  output int          mismatches,
  output int unsigned outstanding
);

  localparam logic [8*64-1:0] IV_FLAT = {
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [80*64-1:0] ROUND_K_FLAT = {
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } digest_beat_t;

  logic [63:0]  chain_h [0:7];
  logic [63:0]  block_buf [0:15];
  int unsigned  slot;
  logic [63:0]  bit_len;
  digest_beat_t digest_expect [$];
  int unsigned  beats_checked;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned n);
    logic [127:0] both;
    both = {x, x} >> n;
    return both[63:0];
  endfunction

  task automatic restart_hash();
    int i;
    for (i = 0; i < 8; i++) chain_h[i] = IV_FLAT[(7 - i)*64 +: 64];
    slot    = 0;
    bit_len = '0;
  endtask

  task automatic compress_block();
    logic [63:0] w [0:79];
    logic [63:0] v [0:7];
    logic [63:0] s0, s1, t1, t2;
    int i;
    for (i = 0; i < 16; i++) w[i] = block_buf[i];
    for (i = 16; i < 80; i++) begin
      s0   = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
      s1   = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (i = 0; i < 8; i++) v[i] = chain_h[i];
    for (i = 0; i < 80; i++) begin
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K_FLAT[(79 - i)*64 +: 64] + w[i];
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic store_word(input logic [63:0] w);
    block_buf[slot] = w;
    slot = (slot + 1) % 16;
    if (slot == 0) compress_block();
  endtask

  task automatic absorb_item(input logic [63:0] data, input logic [3:0] count,
                             input logic last);
    logic [63:0]  keep;
    int unsigned  nbytes;
    digest_beat_t beat;
    int i;
    if (!last) begin
      // Byte count means nothing before the final item of a message.
      bit_len = bit_len + 64'd64;
      store_word(data);
    end else begin
      nbytes  = (count > 4'd8) ? 8 : int'(count);
      bit_len = bit_len + 64'(nbytes * 8);
      if (nbytes == 8) begin
        store_word(data);
        store_word({sha512_pkg::PAD_BYTE, 56'h0});
      end else begin
        keep = (nbytes == 0) ? 64'h0 : (~64'h0 << (64 - 8*nbytes));
        store_word((data & keep) | ({56'h0, sha512_pkg::PAD_BYTE} << (56 - 8*nbytes)));
      end
      // The length takes the last two slots; if they are not free, close this block first.
      if (slot == 0 || slot > 14) begin
        while (slot != 0) store_word('0);
      end
      while (slot < 14) store_word('0);
      store_word('0);
      store_word(bit_len);
      for (i = 0; i < 8; i++) begin
        beat.word = chain_h[i];
        beat.last = (i == 7);
        digest_expect.push_back(beat);
      end
      restart_hash();
    end
  endtask

  always @(posedge clk) begin
    digest_beat_t want;
    if (!rst_n) begin
      restart_hash();
      digest_expect.delete();
      beats_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_expect.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("%0t: unexpected digest item %h last %b", $time,
                     out_digest_word, out_digest_last);
        end else begin
          want = digest_expect.pop_front();
          if (out_digest_word !== want.word || out_digest_last !== want.last) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("%0t: digest item %0d: expected %h last %b, got %h last %b", $time,
                       beats_checked, want.word, want.last, out_digest_word, out_digest_last);
          end
        end
        beats_checked = beats_checked + 1;
      end
      if (in_valid && in_ready) absorb_item(in_data_word, in_byte_count, in_last_word);
    end
    outstanding = digest_expect.size();
  end

endmodule

// ----- sim/tb.sv -----
// Top of the SHA-512 engine testbench: clock, reset, message stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned SETTLE_CYCLES = 200;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [63:0] in_data_word    = '0;
  logic [3:0]  in_byte_count   = '0;
  logic        in_last_word    = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [63:0] out_digest_word;
  logic        out_digest_last;

  int          fail_count;
  int unsigned pending_beats;
  int unsigned cycle_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 88;

  sha512_hash_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_digest_last (out_digest_last)
  );

  sha512_digest_monitor digest_mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_digest_last (out_digest_last),
    .mismatches      (fail_count),
    .outstanding     (pending_beats)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken,
  // with valid still high so that back-to-back items need no second assignment.
  task automatic send_word(input logic [63:0] data, input logic [3:0] count,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= data;
    in_byte_count <= count;
    in_last_word  <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_for_digests();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_beats != 0);
  endtask

  task automatic send_random_message();
    int unsigned full_words;
    logic [3:0]  tail_count;
    int unsigned i;
    // Lengths cluster around the block boundaries, where the padding is hardest.
    case ($urandom_range(3))
      0:       full_words = $urandom_range(3);
      1:       full_words = $urandom_range(17, 12);
      2:       full_words = $urandom_range(31);
      default: full_words = $urandom_range(33, 28);
    endcase
    tail_count = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                          : 4'($urandom_range(8));
    for (i = 0; i < full_words; i++)
      send_word({$urandom, $urandom},
                ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd8, 1'b0);
    send_word({$urandom, $urandom}, tail_count, 1'b1);
  endtask

  initial begin
    int unsigned random_start;
    int unsigned phase;
    int i;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // An empty message, with every data bit set so that all of it must be ignored.
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
    // Three message bytes followed by junk in the ignored low bytes.
    send_word(64'h6162_63FF_FFFF_FFFF, 4'd3, 1'b1);
    // A full final word pushes the padding byte into the following slot.
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
    // Oversized byte counts saturate at eight.
    send_word(64'h0, 4'd15, 1'b1);
    send_word(64'h00FF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
    // Fifteen full words put the padding in the last slot, so the length needs a second block.
    for (i = 0; i < 15; i++)
      send_word((i % 2 == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0, 4'(i), 1'b0);
    send_word(64'hA5A5_5A5A_0F0F_F0F0, 4'd7, 1'b1);

    random_start = items_sent;
    phase = 0;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      if (phase == 0 && items_sent >= random_start + RANDOM_ITEMS / 3) begin
        wait_for_digests();
        send_idle_pct = 88;
        recv_idle_pct = 35;
        phase = 1;
      end else if (phase == 1 && items_sent >= random_start + 2 * RANDOM_ITEMS / 3) begin
        wait_for_digests();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 2;
      end
      send_random_message();
    end

    wait_for_digests();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sha512_pkg.sv
rtl/core/sha512_front.sv
rtl/core/sha512_queue.sv
rtl/core/sha512_back.sv
rtl/core/sha512_hash_engine.sv
rtl/core/sha512_checker.sv
sim/sha512_digest_monitor.sv
sim/tb.sv
